// ===== rtl/core/bpq_pkg.sv =====
// Package for the bucket priority queue core: field widths, request and
// error codes, and the request and result types of the shared arithmetic unit.
// Depends on nothing; every other file of the block but bpq_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package bpq_pkg;

  localparam int ID_W   = 10;
  localparam int KEY_W  = 8;
  localparam int OKEY_W = 9;
  localparam int REQ_W  = 2;
  localparam int ERR_W  = 2;

  localparam logic [KEY_W-1:0]         MAX_KEY_RESET = 8'd255;
  localparam logic signed [OKEY_W-1:0] KEY_ABSENT    = -9'sd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_DEC    = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_KEY_RANGE = 2'd1,
    ERR_DEC_BAD   = 2'd2,
    ERR_PRESENT   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    UOP_LE  = 2'd0,
    UOP_INC = 2'd1,
    UOP_DEC = 2'd2
  } uop_t;

  typedef struct packed {
    uop_t              op;
    logic [OKEY_W-1:0] a;
    logic [OKEY_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic [OKEY_W-1:0] value;
    logic              le;
  } unit_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpq_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on bpq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpq_req_if;
  import bpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ID_W-1:0]   item_id;
  logic [KEY_W-1:0]  key_in;

  modport source (output valid, output req_type, output item_id, output key_in,
                  input ready);
  modport sink (input valid, input req_type, input item_id, input key_in,
                output ready);
endinterface

interface bpq_resp_if;
  import bpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ID_W-1:0]          out_id;
  logic signed [OKEY_W-1:0] out_key;
  logic                     queue_empty;
  logic [ERR_W-1:0]         error_code;

  modport source (output valid, output out_id, output out_key, output queue_empty,
                  output error_code, input ready);
  modport sink (input valid, input out_id, input out_key, input queue_empty,
                input error_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bucket_priority_queue_core.sv =====
// Top level of the bucket priority queue: sequencer, link and key memories.
// Depends on bpq_pkg, bpq_if, bpq_ram and bpq_unit.
//
//   channel   dir  handshake        fields
//   req       in   valid / ready    req_type, item_id, key_in
//   resp      out  valid / ready    out_id, out_key, queue_empty, error_code
//   cfg       in   cfg_we           cfg_wdata (max_key)
//
// A pop skips the empty buckets ahead of the cursor one by one, and a pop of
// an empty queue scans the buckets from the cursor up to the key limit; each
// step that reads a memory waits on its registered read.
// Reset and every write of max_key start a clearing pass over
// max(NUM_ITEMS, NUM_KEYS) addresses, 1024 by default, with req.ready low.
// A finished response waits in an output register while the next request runs;
// the next result then holds the sequencer until that register is taken.
`timescale 1ns / 1ps
`default_nettype none

module bucket_priority_queue_core #(
  parameter int NUM_ITEMS = 1024,
  parameter int NUM_KEYS  = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [bpq_pkg::KEY_W-1:0] cfg_wdata,
  bpq_req_if.sink                        req,
  bpq_resp_if.source                     resp
);
  import bpq_pkg::*;

  localparam int LW        = $clog2(NUM_ITEMS + 1);
  localparam int IW        = $clog2(NUM_ITEMS);
  localparam int KW        = $clog2(NUM_KEYS);
  localparam int CLR_DEPTH = (NUM_ITEMS > NUM_KEYS) ? NUM_ITEMS : NUM_KEYS;
  localparam int CW        = $clog2(CLR_DEPTH);

  localparam logic [LW-1:0]    LINK_NONE = LW'(NUM_ITEMS);
  localparam logic [CW-1:0]    CLR_LAST  = CW'(CLR_DEPTH - 1);
  localparam logic [KEY_W-1:0] KEY_CAP   = (NUM_KEYS - 1 < 255) ? 8'(NUM_KEYS - 1) : 8'd255;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_INS_A, S_LINK_A, S_LINK_B, S_LINK_C, S_DEC_A, S_DEC_B,
    S_DEC_C, S_POP_A, S_POP_B, S_POP_C, S_RD_A, S_RD_B, S_RESP
  } state_t;

  state_t                   state;
  logic [KEY_W-1:0]         max_key;
  logic [OKEY_W-1:0]        cursor;
  logic [CW-1:0]            clr_cnt;
  logic [ID_W-1:0]          id_r;
  logic [KEY_W-1:0]         key_r;
  logic [KEY_W-1:0]         lkey;
  logic [KEY_W-1:0]         okey;
  logic                     chk_r;
  logic [LW-1:0]            p_r;
  logic [LW-1:0]            n_r;
  logic [LW-1:0]            old_r;
  logic [LW-1:0]            h_r;
  logic [ID_W-1:0]          res_id;
  logic signed [OKEY_W-1:0] res_key;
  logic                     res_empty;
  err_t                     res_err;
  logic                     out_valid;
  logic [ID_W-1:0]          out_id;
  logic signed [OKEY_W-1:0] out_key;
  logic                     out_empty;
  err_t                     out_err;

  logic              bh_we, ik_we, nx_we, pv_we;
  logic [KW-1:0]     bh_waddr, bh_raddr;
  logic [IW-1:0]     ik_waddr, ik_raddr, nx_waddr, nx_raddr, pv_waddr, pv_raddr;
  logic [LW-1:0]     bh_wdata, bh_rdata, nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  logic [OKEY_W-1:0] ik_wdata, ik_rdata;

  unit_req_t ureq;
  unit_res_t ures;

  logic [KEY_W-1:0] key_lim;
  logic [IW-1:0]    id_addr;
  logic             id_valid;
  logic             link_ok;
  logic             clr_ik;
  logic             clr_bh;

  assign key_lim  = (max_key < KEY_CAP) ? max_key : KEY_CAP;
  assign id_addr  = IW'(id_r);
  assign id_valid = ({22'd0, id_r} < 32'(NUM_ITEMS));
  assign link_ok  = !(chk_r && !ik_rdata[OKEY_W-1]);
  assign clr_ik   = (32'(clr_cnt) < 32'(NUM_ITEMS));
  assign clr_bh   = (32'(clr_cnt) < 32'(NUM_KEYS));

  assign req.ready        = (state == S_IDLE) && !cfg_we;
  assign resp.valid       = out_valid;
  assign resp.out_id      = out_id;
  assign resp.out_key     = out_key;
  assign resp.queue_empty = out_empty;
  assign resp.error_code  = out_err;

  bpq_unit u_unit (.ureq(ureq), .ures(ures));

  bpq_ram #(.WIDTH(LW), .DEPTH(NUM_KEYS)) u_bucket_head (
    .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(bh_raddr), .rdata(bh_rdata)
  );

  bpq_ram #(.WIDTH(OKEY_W), .DEPTH(NUM_ITEMS)) u_item_key (
    .clk(clk), .we(ik_we), .waddr(ik_waddr), .wdata(ik_wdata),
    .raddr(ik_raddr), .rdata(ik_rdata)
  );

  bpq_ram #(.WIDTH(LW), .DEPTH(NUM_ITEMS)) u_next_link (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  bpq_ram #(.WIDTH(LW), .DEPTH(NUM_ITEMS)) u_prev_link (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );

  always_comb begin
    bh_we    = 1'b0;
    bh_waddr = '0;
    bh_wdata = LINK_NONE;
    bh_raddr = '0;
    ik_we    = 1'b0;
    ik_waddr = '0;
    ik_wdata = KEY_ABSENT;
    ik_raddr = '0;
    nx_we    = 1'b0;
    nx_waddr = '0;
    nx_wdata = LINK_NONE;
    nx_raddr = '0;
    pv_we    = 1'b0;
    pv_waddr = '0;
    pv_wdata = LINK_NONE;
    pv_raddr = '0;
    ureq.op  = UOP_LE;
    ureq.a   = cursor;
    ureq.b   = {1'b0, key_lim};
    case (state)
      S_CLEAR: begin
        ik_we    = clr_ik;
        ik_waddr = clr_cnt[IW-1:0];
        bh_we    = clr_bh;
        bh_waddr = clr_cnt[KW-1:0];
      end
      S_INS_A: begin
        ureq.a   = {1'b0, key_r};
        ik_raddr = id_addr;
        bh_raddr = KW'(key_r);
      end
      S_LINK_A: begin
        bh_raddr = KW'(lkey);
      end
      S_LINK_B: begin
        ik_we    = link_ok;
        ik_waddr = id_addr;
        ik_wdata = {1'b0, lkey};
        nx_we    = link_ok;
        nx_waddr = id_addr;
        nx_wdata = bh_rdata;
        pv_we    = link_ok;
        pv_waddr = id_addr;
        pv_wdata = LINK_NONE;
        bh_we    = link_ok;
        bh_waddr = KW'(lkey);
        bh_wdata = LW'(id_r);
      end
      S_LINK_C: begin
        pv_we    = (old_r < LINK_NONE);
        pv_waddr = old_r[IW-1:0];
        pv_wdata = LW'(id_r);
        ureq.b   = {1'b0, lkey};
      end
      S_DEC_A: begin
        ik_raddr = id_addr;
        nx_raddr = id_addr;
        pv_raddr = id_addr;
      end
      S_DEC_B: begin
        ureq.op = UOP_DEC;
        ureq.a  = ik_rdata;
      end
      S_DEC_C: begin
        if (p_r < LINK_NONE) begin
          nx_we    = 1'b1;
          nx_waddr = p_r[IW-1:0];
          nx_wdata = n_r;
        end else begin
          bh_we    = 1'b1;
          bh_waddr = KW'(okey);
          bh_wdata = n_r;
        end
        pv_we    = (n_r < LINK_NONE);
        pv_waddr = n_r[IW-1:0];
        pv_wdata = p_r;
      end
      S_POP_A: begin
        bh_raddr = KW'(cursor);
      end
      S_POP_B: begin
        ureq.op  = UOP_INC;
        nx_raddr = bh_rdata[IW-1:0];
        ik_raddr = bh_rdata[IW-1:0];
      end
      S_POP_C: begin
        bh_we    = 1'b1;
        bh_waddr = KW'(cursor);
        bh_wdata = nx_rdata;
        pv_we    = (nx_rdata < LINK_NONE);
        pv_waddr = nx_rdata[IW-1:0];
        pv_wdata = LINK_NONE;
        ik_we    = 1'b1;
        ik_waddr = h_r[IW-1:0];
        ik_wdata = KEY_ABSENT;
      end
      S_RD_A: begin
        ik_raddr = id_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      max_key   <= MAX_KEY_RESET;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_key   <= cfg_wdata;
        clr_cnt   <= '0;
        out_valid <= 1'b0;
        state     <= S_CLEAR;
      end else begin
        if (resp.valid && resp.ready && (state != S_RESP)) begin
          out_valid <= 1'b0;
        end
        case (state)
          S_IDLE: begin
            if (req.valid) begin
              id_r      <= req.item_id;
              key_r     <= req.key_in;
              lkey      <= req.key_in;
              chk_r     <= (req_t'(req.req_type) == REQ_INSERT);
              res_id    <= req.item_id;
              res_key   <= KEY_ABSENT;
              res_empty <= 1'b0;
              res_err   <= ERR_OK;
              case (req_t'(req.req_type))
                REQ_INSERT: state <= S_INS_A;
                REQ_POP:    state <= S_POP_A;
                REQ_DEC:    state <= S_DEC_A;
                default:    state <= S_RD_A;
              endcase
            end
          end
          S_CLEAR: begin
            cursor <= {1'b0, max_key} + 9'd1;
            if (clr_cnt == CLR_LAST) begin
              state <= S_IDLE;
            end else begin
              clr_cnt <= clr_cnt + CW'(1);
            end
          end
          S_INS_A: begin
            if (!ures.le) begin
              res_err <= ERR_KEY_RANGE;
              state   <= S_RESP;
            end else if (!id_valid) begin
              res_err <= ERR_PRESENT;
              state   <= S_RESP;
            end else begin
              state <= S_LINK_B;
            end
          end
          S_LINK_A: begin
            state <= S_LINK_B;
          end
          S_LINK_B: begin
            if (!link_ok) begin
              res_err <= ERR_PRESENT;
              state   <= S_RESP;
            end else begin
              old_r <= bh_rdata;
              state <= S_LINK_C;
            end
          end
          S_LINK_C: begin
            if (!ures.le) begin
              cursor <= {1'b0, lkey};
            end
            res_key <= signed'({1'b0, lkey});
            state   <= S_RESP;
          end
          S_DEC_A: begin
            if (!id_valid) begin
              res_err <= ERR_DEC_BAD;
              state   <= S_RESP;
            end else begin
              state <= S_DEC_B;
            end
          end
          S_DEC_B: begin
            if (ik_rdata[OKEY_W-1] || (ik_rdata == '0)) begin
              res_err <= ERR_DEC_BAD;
              state   <= S_RESP;
            end else begin
              okey  <= ik_rdata[KEY_W-1:0];
              lkey  <= ures.value[KEY_W-1:0];
              p_r   <= pv_rdata;
              n_r   <= nx_rdata;
              chk_r <= 1'b0;
              state <= S_DEC_C;
            end
          end
          S_DEC_C: begin
            state <= S_LINK_A;
          end
          S_POP_A: begin
            if (!ures.le) begin
              res_id    <= '0;
              res_key   <= KEY_ABSENT;
              res_empty <= 1'b1;
              state     <= S_RESP;
            end else begin
              state <= S_POP_B;
            end
          end
          S_POP_B: begin
            if (bh_rdata < LINK_NONE) begin
              h_r   <= bh_rdata;
              state <= S_POP_C;
            end else begin
              cursor <= ures.value;
              state  <= S_POP_A;
            end
          end
          S_POP_C: begin
            res_id  <= ID_W'(h_r);
            res_key <= signed'(ik_rdata);
            state   <= S_RESP;
          end
          S_RD_A: begin
            if (id_valid) begin
              state <= S_RD_B;
            end else begin
              state <= S_RESP;
            end
          end
          S_RD_B: begin
            res_key <= signed'(ik_rdata);
            state   <= S_RESP;
          end
          S_RESP: begin
            if (!out_valid || resp.ready) begin
              out_valid <= 1'b1;
              out_id    <= res_id;
              out_key   <= res_key;
              out_empty <= res_empty;
              out_err   <= res_err;
              state     <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bpq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/bpq_unit.sv =====
// Shared compare, increment and decrement unit used by the sequencer.
// Depends on bpq_pkg for the unit request and result types.
`timescale 1ns / 1ps
`default_nettype none

module bpq_unit (
  input  wire bpq_pkg::unit_req_t ureq,
  output bpq_pkg::unit_res_t      ures
);
  import bpq_pkg::*;

  always_comb begin
    ures.le = (ureq.a <= ureq.b);
    case (ureq.op)
      UOP_INC: ures.value = ureq.a + 9'd1;
      UOP_DEC: ures.value = ureq.a - 9'd1;
      default: ures.value = ureq.a;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/bpq_checker.sv =====
// Port-level checker for the bucket priority queue core and its bind statement.
// Depends on bpq_pkg for field widths and on the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

module bpq_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             cfg_we,
  input wire logic                             req_valid,
  input wire logic                             req_ready,
  input wire logic                             resp_valid,
  input wire logic                             resp_ready,
  input wire logic [bpq_pkg::ID_W-1:0]         out_id,
  input wire logic signed [bpq_pkg::OKEY_W-1:0] out_key,
  input wire logic                             queue_empty,
  input wire logic [bpq_pkg::ERR_W-1:0]        error_code
);
  import bpq_pkg::*;

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = req_valid && req_ready;
  assign out_acc = resp_valid && resp_ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pending <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  // Reset and a max_key write both start the clearing pass.
  assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted right after reset");

  assert property (@(posedge clk) disable iff (rst) cfg_we |=> !req_ready)
    else $error("request accepted right after a max_key write");

  assert property (@(posedge clk) disable iff (rst) resp_valid |-> pending != 3'd0)
    else $error("response without an outstanding transaction");

  assert property (@(posedge clk) disable iff (rst) pending <= 3'd2)
    else $error("more than two transactions in flight");

  assert property (@(posedge clk) disable iff (rst)
    (resp_valid && !resp_ready && !cfg_we) |=>
      (resp_valid && $stable(out_id) && $stable(out_key) && $stable(queue_empty)
       && $stable(error_code)))
    else $error("stalled response changed");

endmodule

bind bucket_priority_queue_core bpq_checker u_bpq_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_we     (cfg_we),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .out_id     (resp.out_id),
  .out_key    (resp.out_key),
  .queue_empty(resp.queue_empty),
  .error_code (resp.error_code)
);

`default_nettype wire
